>>> rtl/core/lms_pkg.sv
// Shared types and constants for the linear move stepper.
package lms_pkg;

    // Operation codes carried by an input item
    localparam logic [2:0] OP_BEGIN = 3'd0;
    localparam logic [2:0] OP_END   = 3'd1;
    localparam logic [2:0] OP_NEXT  = 3'd2;
    localparam logic [2:0] OP_PREV  = 3'd3;
    localparam logic [2:0] OP_FWD   = 3'd4;
    localparam logic [2:0] OP_BACK  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_VECTOR_X   = 2'd0;
    localparam logic [1:0] CFG_VECTOR_Y   = 2'd1;
    localparam logic [1:0] CFG_BEAT_COUNT = 2'd2;

    localparam int          COORD_W   = 16;
    localparam int          BEAT_W    = 16;
    localparam int          COUNT_W   = 15;
    localparam int          DVD_W     = 32;
    localparam int          DIV_STEPS = DVD_W;
    localparam logic [15:0] BEAT_MAX  = 16'hFFFF;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } lms_state_t;

endpackage

>>> rtl/core/lms_div.sv
// Radix-2 restoring divider, unsigned 32-bit dividend by 15-bit divisor, one bit per cycle.
module lms_div
    import lms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DVD_W-1:0]     dividend,
    input  logic [COUNT_W-1:0]   divisor,
    output logic                 done,
    output logic [DVD_W-1:0]     quotient
);

    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] dsr_reg;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               ge;

    // One trial subtraction per cycle; quotient bits shift in behind the dividend
    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], ge};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            dvd_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> rtl/core/beat_linear_move_stepper_top.sv
// Top level of the linear move stepper: sequencer, shared multiplier and divider.
// Begin, end, apply and non-moving steps go from accept straight to the finish state,
// which loads the output register once it is free. A moving next or previous step runs
// 4 divisions in turn (multiply, load, divider iterations, done), then finishes; the
// one radix-2 divider serves all four. s_ready is high only while the sequencer is idle,
// and a result left waiting holds it low, so a new item waits until the last has gone.
// Synchronous active-low reset clears the state, beat counter, config and m_valid.
module beat_linear_move_stepper_top
    import lms_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_wdata,
    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_operation,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    // result items
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_new_x,
    output logic signed [COORD_W-1:0] m_new_y,
    output logic                      m_more,
    output logic [BEAT_W-1:0]         m_beat_now
);

    lms_state_t state_reg, state_next;

    logic [COORD_W-1:0] vx_reg, vy_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [BEAT_W-1:0]  beat_reg;
    logic [BEAT_W-1:0]  b_new_reg, b_old_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg;
    logic               more_reg;
    logic [1:0]         job_reg;
    logic [DVD_W-1:0]   mag_reg;
    logic               neg_reg;

    logic               m_valid_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic               out_more_reg;
    logic [BEAT_W-1:0]  out_beat_reg;

    logic               accept;
    logic               need_div;
    logic               div_start;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic               out_load;
    logic               last_job;

    logic [BEAT_W-1:0]  mul_b;
    logic [COORD_W-1:0] mul_v;
    logic [COORD_W-1:0] abs_v;
    logic [COORD_W-1:0] term;

    // Step that actually moves needs the divider
    always_comb begin
        need_div = 1'b0;
        if (n_reg != '0) begin
            if (s_operation == OP_NEXT && beat_reg != BEAT_MAX) begin
                need_div = 1'b1;
            end else if (s_operation == OP_PREV && beat_reg != '0) begin
                need_div = 1'b1;
            end
        end
    end

    assign accept   = s_valid && s_ready;
    assign last_job = (job_reg == 2'd3);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = need_div ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = last_job ? ST_FIN : ST_MUL;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready   = 1'b1;
            ST_LOAD: div_start = 1'b1;
            ST_FIN:  out_load  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vx_reg <= '0;
            vy_reg <= '0;
            n_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_VECTOR_X:   vx_reg <= cfg_wdata;
                CFG_VECTOR_Y:   vy_reg <= cfg_wdata;
                CFG_BEAT_COUNT: n_reg  <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Beat counter, settled at accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= '0;
        end else if (accept) begin
            case (s_operation)
                OP_BEGIN, OP_BACK: beat_reg <= '0;
                OP_END, OP_FWD:    beat_reg <= {1'b0, n_reg};
                OP_NEXT: begin
                    if (beat_reg != BEAT_MAX) beat_reg <= beat_reg + 16'd1;
                end
                OP_PREV: begin
                    if (beat_reg != '0) beat_reg <= beat_reg - 16'd1;
                end
                default: ;
            endcase
        end
    end

    // Shared multiplier operands: job bit 0 picks the beat, bit 1 the axis
    assign mul_b = job_reg[0] ? b_old_reg : b_new_reg;
    assign mul_v = job_reg[1] ? vy_reg : vx_reg;
    assign abs_v = mul_v[COORD_W-1] ? (~mul_v + 16'd1) : mul_v;

    // Signed quotient, only the low sixteen bits matter since the point wraps
    assign term = neg_reg ? (~div_q[COORD_W-1:0] + 16'd1) : div_q[COORD_W-1:0];

    // Working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg    <= s_pos_x;
            py_reg    <= s_pos_y;
            b_old_reg <= beat_reg;
            job_reg   <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            more_reg  <= 1'b0;
            b_new_reg <= beat_reg;
            case (s_operation)
                OP_BEGIN: begin
                    if (n_reg == '0) begin
                        dx_reg <= vx_reg;
                        dy_reg <= vy_reg;
                    end else begin
                        more_reg <= 1'b1;
                    end
                end
                OP_END: begin
                    if (n_reg == '0) begin
                        dx_reg <= ~vx_reg + 16'd1;
                        dy_reg <= ~vy_reg + 16'd1;
                    end else begin
                        more_reg <= 1'b1;
                    end
                end
                OP_NEXT: begin
                    if (beat_reg != BEAT_MAX) begin
                        b_new_reg <= beat_reg + 16'd1;
                        more_reg  <= ((beat_reg + 16'd1) < {1'b0, n_reg});
                    end else begin
                        more_reg  <= 1'b0;
                    end
                end
                OP_PREV: begin
                    if (beat_reg != '0) begin
                        b_new_reg <= beat_reg - 16'd1;
                        more_reg  <= 1'b1;
                    end
                end
                OP_FWD: begin
                    dx_reg <= vx_reg;
                    dy_reg <= vy_reg;
                end
                OP_BACK: begin
                    dx_reg <= ~vx_reg + 16'd1;
                    dy_reg <= ~vy_reg + 16'd1;
                end
                default: ;
            endcase
        end else begin
            case (state_reg)
                ST_MUL: begin
                    mag_reg <= DVD_W'(mul_b) * DVD_W'(abs_v);
                    neg_reg <= mul_v[COORD_W-1];
                end
                ST_DIV: begin
                    if (div_done) begin
                        // new-beat part added, old-beat part subtracted
                        if (!job_reg[1]) begin
                            dx_reg <= job_reg[0] ? (dx_reg - term) : (dx_reg + term);
                        end else begin
                            dy_reg <= job_reg[0] ? (dy_reg - term) : (dy_reg + term);
                        end
                        job_reg <= job_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    lms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg    <= px_reg + dx_reg;
            out_y_reg    <= py_reg + dy_reg;
            out_more_reg <= more_reg;
            out_beat_reg <= beat_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_new_x    = out_x_reg;
    assign m_new_y    = out_y_reg;
    assign m_more     = out_more_reg;
    assign m_beat_now = out_beat_reg;

endmodule

>>> sim/lms_checker.sv
// Result checker for the linear move stepper: tracks the beat counter and compares every result.
module lms_checker
    import lms_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [2:0]                s_operation,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [COORD_W-1:0] m_new_x,
    input  logic signed [COORD_W-1:0] m_new_y,
    input  logic                      m_more,
    input  logic [BEAT_W-1:0]         m_beat_now,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               more;
        logic [BEAT_W-1:0]  beat;
    } move_result_t;

    // Shadow of the configuration and the beat counter
    logic signed [COORD_W-1:0] move_vx;
    logic signed [COORD_W-1:0] move_vy;
    logic [COUNT_W-1:0]        move_beats;
    logic [BEAT_W-1:0]         beat_pos;

    move_result_t              due_q[$];
    int                        n_fail;

    initial begin
        n_fail     = 0;
        fail_count = 0;
        pending    = 0;
    end

    // Part of a component reached at beat b, truncated toward zero
    function automatic longint beat_share(logic [BEAT_W-1:0] b, logic signed [COORD_W-1:0] v,
                                          logic [COUNT_W-1:0] n);
        longint lb;
        longint lv;
        longint ln;
        lb = b;
        lv = v;
        ln = n;
        return (lb * lv) / ln;
    endfunction

    // Point, flag and beat after one operation from beat b
    function automatic move_result_t next_point(logic [2:0] op, logic signed [COORD_W-1:0] px,
                                                logic signed [COORD_W-1:0] py,
                                                logic [BEAT_W-1:0] b);
        move_result_t r;
        longint       nx;
        longint       ny;
        logic         more;
        nx   = px;
        ny   = py;
        more = 1'b0;
        case (op)
            OP_BEGIN: begin
                b = '0;
                if (move_beats == 0) begin
                    nx += move_vx;
                    ny += move_vy;
                end else begin
                    more = 1'b1;
                end
            end
            OP_END: begin
                b = {1'b0, move_beats};
                if (move_beats == 0) begin
                    nx -= move_vx;
                    ny -= move_vy;
                end else begin
                    more = 1'b1;
                end
            end
            OP_NEXT: begin
                // counter saturates; no move at the top
                if (b != BEAT_MAX) begin
                    b = b + 16'd1;
                    if (move_beats != 0) begin
                        nx += beat_share(b, move_vx, move_beats)
                            - beat_share(b - 16'd1, move_vx, move_beats);
                        ny += beat_share(b, move_vy, move_beats)
                            - beat_share(b - 16'd1, move_vy, move_beats);
                    end
                end
                more = (b < {1'b0, move_beats});
            end
            OP_PREV: begin
                // at beat zero nothing moves and the flag is low
                if (b != 0) begin
                    b = b - 16'd1;
                    if (move_beats != 0) begin
                        nx += beat_share(b, move_vx, move_beats)
                            - beat_share(b + 16'd1, move_vx, move_beats);
                        ny += beat_share(b, move_vy, move_beats)
                            - beat_share(b + 16'd1, move_vy, move_beats);
                    end
                    more = 1'b1;
                end
            end
            OP_FWD: begin
                b = {1'b0, move_beats};
                nx += move_vx;
                ny += move_vy;
            end
            OP_BACK: begin
                b = '0;
                nx -= move_vx;
                ny -= move_vy;
            end
            default: begin
            end
        endcase
        r.x    = nx[COORD_W-1:0];
        r.y    = ny[COORD_W-1:0];
        r.more = more;
        r.beat = b;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        move_result_t want;
        if (!aresetn) begin
            move_vx    = '0;
            move_vy    = '0;
            move_beats = '0;
            beat_pos   = '0;
            due_q.delete();
        end else begin
            // register writes; unknown index ignored
            if (cfg_we) begin
                case (cfg_index)
                    CFG_VECTOR_X:   move_vx    = cfg_wdata;
                    CFG_VECTOR_Y:   move_vy    = cfg_wdata;
                    CFG_BEAT_COUNT: move_beats = cfg_wdata[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // result side: compare against the oldest expectation
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: result with nothing expected, got x=%h y=%h more=%b beat=%h",
                             $time, m_new_x, m_new_y, m_more, m_beat_now);
                end else begin
                    want = due_q.pop_front();
                    check_field("new_x", want.x, m_new_x);
                    check_field("new_y", want.y, m_new_y);
                    check_field("more", {15'd0, want.more}, {15'd0, m_more});
                    check_field("beat_now", want.beat, m_beat_now);
                end
            end

            // input side: predict and queue
            if (s_valid && s_ready) begin
                want = next_point(s_operation, s_pos_x, s_pos_y, beat_pos);
                beat_pos = want.beat;
                due_q.push_back(want);
            end
        end
        pending    <= due_q.size();
        fail_count <= n_fail;
    end

endmodule

>>> sim/tb.sv
// Testbench top for the linear move stepper: clock, reset, item stimulus and verdict.
module tb;
    import lms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_6   = 3'd6;
    localparam logic [2:0] OP_SPARE_7   = 3'd7;
    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam int         STOP_CYCLES  = 1_000_000;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 150;
    localparam int         RANDOM_ITEMS = 650;
    localparam int         QUIET_FROM   = 560;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [15:0]               cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic [2:0]                s_operation;
    logic signed [COORD_W-1:0] s_pos_x;
    logic signed [COORD_W-1:0] s_pos_y;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [COORD_W-1:0] m_new_x;
    logic signed [COORD_W-1:0] m_new_y;
    logic                      m_more;
    logic [BEAT_W-1:0]         m_beat_now;

    int fail_count;
    int pending;
    int cycles;
    int items_sent;
    bit quiet;
    bit hold_req;

    beat_linear_move_stepper_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_x     (m_new_x),
        .m_new_y     (m_new_y),
        .m_more      (m_more),
        .m_beat_now  (m_beat_now)
    );

    lms_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_x     (m_new_x),
        .m_new_y     (m_new_y),
        .m_more      (m_more),
        .m_beat_now  (m_beat_now),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= STOP_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Coordinates biased toward the extremes and small values
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item, with an occasional gap first, and wait until it is taken
    task automatic push_item(logic [2:0] op, logic [15:0] px, logic [15:0] py);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_pos_x     <= px;
        s_pos_y     <= py;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_move(logic [15:0] vx, logic [15:0] vy, logic [15:0] n_word);
        settle();
        write_reg(CFG_VECTOR_X, vx);
        write_reg(CFG_VECTOR_Y, vy);
        write_reg(CFG_BEAT_COUNT, n_word);
    endtask

    // Well-formed pass over a move: begin, walk forward, back, end, apply
    task automatic walk_move(int n_beats);
        int steps;
        steps = (n_beats > 38) ? 40 : n_beats + $urandom_range(0, 2);
        push_item(OP_BEGIN, pick_coord(), pick_coord());
        repeat (steps) push_item(OP_NEXT, pick_coord(), pick_coord());
        repeat ($urandom_range(0, steps + 1)) push_item(OP_PREV, pick_coord(), pick_coord());
        push_item(OP_END, pick_coord(), pick_coord());
        repeat ($urandom_range(0, 3)) push_item(OP_PREV, pick_coord(), pick_coord());
        if ($urandom_range(0, 2) == 0)
            push_item(OP_NEXT, pick_coord(), pick_coord());
        if ($urandom_range(0, 1) == 0)
            push_item(OP_FWD, pick_coord(), pick_coord());
        else
            push_item(OP_BACK, pick_coord(), pick_coord());
    endtask

    // Result side: random back-pressure bursts and one long hold-off on request
    initial begin : result_sink
        int burst;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 9);
                m_ready <= 1'b0;
                repeat (burst) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int n_beats;
        int phase;
        int base;
        logic [15:0] vx;
        logic [15:0] vy;

        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_operation = OP_BEGIN;
        s_pos_x     = '0;
        s_pos_y     = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        items_sent  = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: zero vector, zero beats
        push_item(OP_BEGIN, 16'h1234, 16'hEDCB);
        push_item(OP_PREV, 16'h0001, 16'hFFFF);
        push_item(OP_NEXT, 16'h7FFF, 16'h8000);

        // zero beats with extreme vector: whole vector at once, wrapping
        set_move(16'h7FFF, 16'h8000, 16'h0000);
        push_item(OP_BEGIN, 16'h7FFF, 16'h8000);
        push_item(OP_END, 16'h8000, 16'h7FFF);
        push_item(OP_NEXT, 16'h0000, 16'h0000);
        push_item(OP_PREV, 16'hFFFF, 16'h0001);
        push_item(OP_FWD, 16'h0001, 16'hFFFF);
        push_item(OP_BACK, 16'h8000, 16'h8000);
        push_item(OP_SPARE_6, 16'h5555, 16'hAAAA);
        push_item(OP_SPARE_7, 16'hAAAA, 16'h5555);

        // one beat, and stepping past the end of the move
        set_move(16'h8000, 16'h7FFF, 16'h0001);
        push_item(OP_BEGIN, 16'h0000, 16'h0000);
        push_item(OP_NEXT, 16'h0000, 16'h0000);
        push_item(OP_NEXT, 16'h7FFF, 16'h8000);
        push_item(OP_PREV, 16'h0000, 16'h0000);
        push_item(OP_PREV, 16'h0000, 16'h0000);
        push_item(OP_PREV, 16'h0000, 16'h0000);

        // negative components: truncation toward zero
        set_move(16'hFFF9, 16'h0005, 16'h0003);
        push_item(OP_END, 16'h0010, 16'hFFF0);
        repeat (3) push_item(OP_PREV, 16'h0000, 16'h0000);
        repeat (3) push_item(OP_NEXT, 16'h0000, 16'h0000);

        // large beat counter: park at the largest count, then step with zero beats
        set_move(16'h0064, 16'hFF9C, 16'hFFFF);
        push_item(OP_END, 16'h0000, 16'h0000);
        set_move(16'h0064, 16'hFF9C, 16'h0000);
        repeat (4) push_item(OP_NEXT, 16'($urandom), 16'($urandom));
        push_item(OP_NEXT, 16'h4321, 16'h1234);
        push_item(OP_PREV, 16'h4321, 16'h1234);

        // random moves
        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (items_sent - base >= QUIET_FROM)
                quiet = 1'b1;
            vx = pick_coord();
            vy = pick_coord();
            case ($urandom_range(0, 19))
                0:       n_beats = 32767;
                1, 2:    n_beats = $urandom_range(13, 300);
                default: n_beats = $urandom_range(0, 12);
            endcase
            set_move(vx, vy, {1'($urandom_range(0, 1)), 15'(n_beats)});
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_UNUSED, 16'($urandom));
            if (phase == 3)
                hold_req = 1'b1;
            if ($urandom_range(0, 9) < 7) begin
                walk_move(n_beats);
            end else begin
                repeat ($urandom_range(4, 12))
                    push_item(3'($urandom_range(0, 7)), pick_coord(), pick_coord());
            end
            phase++;
        end

        // drain and let the block go quiet
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/lms_pkg.sv
rtl/core/lms_div.sv
rtl/core/beat_linear_move_stepper_top.sv
sim/lms_checker.sv
sim/tb.sv
